FILE: rtl/adsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared constants, codes and types for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int COUNT_BITS      = 32;
    localparam int LEVEL_FRAC_BITS = 15;

    localparam int TICK_W  = 24;
    localparam int LVL_W   = 16;
    localparam int PH_W    = 2;
    localparam int PROD_W  = TICK_W + LVL_W;
    localparam int IDX_W   = 3;

    localparam int DIV_STEPS = LVL_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [LVL_W-1:0] SMALL_LEVEL =
        LVL_W'((64'd1 << LEVEL_FRAC_BITS) / 64'd10000);

    localparam logic [TICK_W-1:0] ATTACK_RST  = TICK_W'(4800);
    localparam logic [TICK_W-1:0] DECAY_RST   = TICK_W'(480);
    localparam logic [TICK_W-1:0] RELEASE_RST = TICK_W'(9600);
    localparam logic [LVL_W-1:0]  START_RST   = LVL_W'(32768);
    localparam logic [LVL_W-1:0]  SUSTAIN_RST = LVL_W'(26214);

    typedef enum logic [IDX_W-1:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_RELEASE = 3'd2,
        REG_START   = 3'd3,
        REG_SUSTAIN = 3'd4
    } reg_idx_t;

    typedef enum logic [PH_W-1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2,
        PH_RELEASE = 2'd3
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

endpackage

FILE: rtl/adsr_envelope_generator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// Linear ADSR envelope: one level and phase per sample tick transfer.
// Each tick transfer runs a multiply step, 16 restoring divide steps and a
// finish step; the input is ready again only when the finish is done, so a
// new tick is taken only after the last one has passed through the shared
// one-bit-per-cycle divider. A waiting result stalls the finish.
// Reset: asynchronous, active low; gate clear, counters zero, registers at
// their default values, no result pending.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_unit
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [adsr_pkg::IDX_W-1:0]   cfg_index,
    input  logic [adsr_pkg::TICK_W-1:0]  cfg_data,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // note_on, note_off, zero pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [23:0]                  m_tdata    // level[15:0], phase[17:16], zero pad
);

    localparam int CW = adsr_pkg::COUNT_BITS;
    localparam int TW = adsr_pkg::TICK_W;
    localparam int LW = adsr_pkg::LVL_W;

    adsr_pkg::state_t state_reg, state_next;

    logic [TW-1:0] attack_reg, decay_reg, release_reg;
    logic [LW-1:0] start_reg, sustain_reg;

    logic          gate_reg;
    logic [CW-1:0] since_on_reg, since_off_reg;

    logic [TW-1:0]             x_reg;
    logic [LW-1:0]             mult_reg;
    logic [TW-1:0]             div_reg;
    logic [LW-1:0]             base_reg;
    logic                      add_reg;
    logic [adsr_pkg::PH_W-1:0] phase_reg;
    logic [TW-1:0]             rem_reg;
    logic [LW-1:0]             quo_reg;
    logic [adsr_pkg::STEP_W-1:0] step_reg;

    logic          out_valid_reg;
    logic [LW-1:0] out_level_reg;
    logic [adsr_pkg::PH_W-1:0] out_phase_reg;

    logic          in_xfer;
    logic          note_on, note_off;
    logic          gate_new;
    logic [CW-1:0] t_eff, s_eff, t_minus_a;
    logic [CW-1:0] a_ext, ad_ext, r_ext;
    logic          in_attack, in_decay, rel_done;
    logic          slot_free;

    logic [adsr_pkg::PROD_W-1:0] prod;
    logic [TW+1:0] trial;
    logic          ge;
    logic [LW:0]   sum;
    logic [LW-1:0] lvl;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == adsr_pkg::ST_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign note_on   = s_tdata[0];
    assign note_off  = s_tdata[1];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_phase_reg, out_level_reg};

    // event handling and phase selection
    always_comb
    begin
        gate_new  = note_off ? 1'b0 : (note_on ? 1'b1 : gate_reg);
        t_eff     = note_on  ? '0 : since_on_reg;
        s_eff     = note_off ? '0 : since_off_reg;
        a_ext     = CW'(attack_reg);
        r_ext     = CW'(release_reg);
        ad_ext    = CW'({1'b0, attack_reg} + {1'b0, decay_reg});
        t_minus_a = t_eff - a_ext;
        in_attack = (attack_reg != '0) && (t_eff <= a_ext);
        in_decay  = (decay_reg != '0) && (t_eff <= ad_ext);
        rel_done  = (release_reg == '0) || (s_eff >= r_ext);
    end

    assign prod  = adsr_pkg::PROD_W'(x_reg) * adsr_pkg::PROD_W'(mult_reg);
    assign trial = {1'b0, rem_reg, quo_reg[LW-1]} - {2'b00, div_reg};
    assign ge    = !trial[TW+1];
    assign sum   = add_reg ? ({1'b0, base_reg} + {1'b0, quo_reg})
                           : ({1'b0, base_reg} - {1'b0, quo_reg});
    assign lvl   = (sum[LW-1:0] <= adsr_pkg::SMALL_LEVEL) ? '0 : sum[LW-1:0];
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            adsr_pkg::ST_IDLE: if (in_xfer) state_next = adsr_pkg::ST_MUL;
            adsr_pkg::ST_MUL:  state_next = adsr_pkg::ST_DIV;
            adsr_pkg::ST_DIV:
                if (step_reg == adsr_pkg::STEP_W'(adsr_pkg::DIV_STEPS - 1))
                    state_next = adsr_pkg::ST_FIN;
            adsr_pkg::ST_FIN:  if (slot_free) state_next = adsr_pkg::ST_IDLE;
            default:           state_next = adsr_pkg::ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= adsr_pkg::ATTACK_RST;
            decay_reg   <= adsr_pkg::DECAY_RST;
            release_reg <= adsr_pkg::RELEASE_RST;
            start_reg   <= adsr_pkg::START_RST;
            sustain_reg <= adsr_pkg::SUSTAIN_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                adsr_pkg::REG_ATTACK:  attack_reg  <= cfg_data;
                adsr_pkg::REG_DECAY:   decay_reg   <= cfg_data;
                adsr_pkg::REG_RELEASE: release_reg <= cfg_data;
                adsr_pkg::REG_START:   start_reg   <= cfg_data[LW-1:0];
                adsr_pkg::REG_SUSTAIN: sustain_reg <= cfg_data[LW-1:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= adsr_pkg::ST_IDLE;
            gate_reg      <= 1'b0;
            since_on_reg  <= '0;
            since_off_reg <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                gate_reg      <= gate_new;
                since_on_reg  <= (t_eff == adsr_pkg::CNT_MAX) ? t_eff : t_eff + 1'b1;
                since_off_reg <= (s_eff == adsr_pkg::CNT_MAX) ? s_eff : s_eff + 1'b1;
            end
            if (state_reg == adsr_pkg::ST_MUL)
                step_reg <= '0;
            else if (state_reg == adsr_pkg::ST_DIV)
                step_reg <= step_reg + 1'b1;
            if (state_reg == adsr_pkg::ST_FIN && slot_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath: operand setup, multiply, restoring divide, result
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            if (gate_new && in_attack)
            begin
                x_reg     <= t_eff[TW-1:0];
                mult_reg  <= start_reg;
                div_reg   <= attack_reg;
                base_reg  <= '0;
                add_reg   <= 1'b1;
                phase_reg <= adsr_pkg::PH_ATTACK;
            end
            else if (gate_new && in_decay)
            begin
                x_reg     <= t_minus_a[TW-1:0];
                mult_reg  <= (sustain_reg >= start_reg) ? sustain_reg - start_reg
                                                        : start_reg - sustain_reg;
                div_reg   <= decay_reg;
                base_reg  <= start_reg;
                add_reg   <= (sustain_reg >= start_reg);
                phase_reg <= adsr_pkg::PH_DECAY;
            end
            else if (gate_new)
            begin
                x_reg     <= '0;
                mult_reg  <= '0;
                div_reg   <= TW'(1);
                base_reg  <= sustain_reg;
                add_reg   <= 1'b0;
                phase_reg <= adsr_pkg::PH_SUSTAIN;
            end
            else if (rel_done)
            begin
                x_reg     <= '0;
                mult_reg  <= '0;
                div_reg   <= TW'(1);
                base_reg  <= '0;
                add_reg   <= 1'b0;
                phase_reg <= adsr_pkg::PH_RELEASE;
            end
            else
            begin
                x_reg     <= s_eff[TW-1:0];
                mult_reg  <= sustain_reg;
                div_reg   <= release_reg;
                base_reg  <= sustain_reg;
                add_reg   <= 1'b0;
                phase_reg <= adsr_pkg::PH_RELEASE;
            end
        end
        if (state_reg == adsr_pkg::ST_MUL)
        begin
            rem_reg <= prod[adsr_pkg::PROD_W-1:LW];
            quo_reg <= prod[LW-1:0];
        end
        else if (state_reg == adsr_pkg::ST_DIV)
        begin
            rem_reg <= ge ? trial[TW-1:0] : {rem_reg[TW-2:0], quo_reg[LW-1]};
            quo_reg <= {quo_reg[LW-2:0], ge};
        end
        if (state_reg == adsr_pkg::ST_FIN && slot_free)
        begin
            out_level_reg <= lvl;
            out_phase_reg <= phase_reg;
        end
    end

    a_start_mul: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == adsr_pkg::ST_MUL)
        else $error("transfer did not start the multiply step");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == adsr_pkg::ST_DIV |-> div_reg != '0)
        else $error("divide with zero divisor");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == adsr_pkg::ST_DIV |-> rem_reg < div_reg)
        else $error("partial remainder out of range");

    a_on_count: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !note_on && since_on_reg != adsr_pkg::CNT_MAX
        |=> since_on_reg == $past(since_on_reg) + 1'b1)
        else $error("note-on counter did not advance");

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the linear ADSR envelope generator. Sample ticks
// carrying note-on and note-off events are streamed in, and every level and
// phase that comes back is compared with a cycle-free envelope predictor
// that tracks the gate, the tick counters and the register settings. Directed
// cases cover reset, every phase, zero-length phases, level extremes and
// unused register indexes. Random note sequences then run under many register
// settings with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ITEM_GOAL        = 1850;
    localparam int FULL_SCALE       = 1 << adsr_pkg::LEVEL_FRAC_BITS;
    localparam int FIRST_UNUSED_IDX = 5;
    localparam int DRAIN_CYCLES     = 40;
    localparam int IW               = adsr_pkg::IDX_W;
    localparam int TW               = adsr_pkg::TICK_W;
    localparam int LW               = adsr_pkg::LVL_W;

    typedef struct packed {
        logic [LW-1:0]     level;
        adsr_pkg::phase_t  phase;
    } envelope_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [IW-1:0]     cfg_index = '0;
    logic [TW-1:0]     cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata   = '0;   // note_on, note_off, zero pad
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [23:0]       m_tdata;          // level[15:0], phase[17:16], zero pad

    // predictor copy of the registers and the envelope state
    logic [TW-1:0]     attack_q  = adsr_pkg::ATTACK_RST;
    logic [TW-1:0]     decay_q   = adsr_pkg::DECAY_RST;
    logic [TW-1:0]     release_q = adsr_pkg::RELEASE_RST;
    logic [LW-1:0]     start_q   = adsr_pkg::START_RST;
    logic [LW-1:0]     sustain_q = adsr_pkg::SUSTAIN_RST;
    logic              gate_q    = 1'b0;
    logic [adsr_pkg::COUNT_BITS-1:0] since_on_q  = '0;
    logic [adsr_pkg::COUNT_BITS-1:0] since_off_q = '0;

    envelope_t   expected_env[$];
    int unsigned ticks_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatches    = 0;
    int unsigned tx_burst_left = 0;
    bit          tx_raised     = 1'b0;
    bit          tx_gapless    = 1'b0;
    bit          cfg_raised    = 1'b0;
    bit          rx_stalls     = 1'b1;
    bit          rx_open       = 1'b0;
    int unsigned rx_run        = 0;

    adsr_envelope_generator_unit DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic envelope_t advance_envelope(input bit on, input bit off);
        longint unsigned t, s, a, d, r, st, su, lvl;
        longint          diff, num, v;
        envelope_t       e;
        if (on)
        begin
            gate_q     = 1'b1;
            since_on_q = '0;
        end
        if (off)
        begin
            gate_q      = 1'b0;
            since_off_q = '0;
        end
        t  = since_on_q;
        s  = since_off_q;
        a  = attack_q;
        d  = decay_q;
        r  = release_q;
        st = start_q;
        su = sustain_q;
        if (gate_q)
        begin
            if (a != 0 && t <= a)
            begin
                lvl     = (t * st) / a;
                e.phase = adsr_pkg::PH_ATTACK;
            end
            else if (d != 0 && t <= a + d)
            begin
                diff    = longint'(su) - longint'(st);
                num     = longint'(t - a) * diff;
                v       = longint'(st) + num / longint'(d);
                lvl     = (v < 0) ? 0 : longint'(v);
                e.phase = adsr_pkg::PH_DECAY;
            end
            else
            begin
                lvl     = su;
                e.phase = adsr_pkg::PH_SUSTAIN;
            end
        end
        else
        begin
            if (r == 0 || s >= r)
                lvl = 0;
            else
                lvl = su - (s * su) / r;
            e.phase = adsr_pkg::PH_RELEASE;
        end
        if (lvl <= adsr_pkg::SMALL_LEVEL)
            lvl = 0;
        if (since_on_q != adsr_pkg::CNT_MAX)
            since_on_q = since_on_q + 1'b1;
        if (since_off_q != adsr_pkg::CNT_MAX)
            since_off_q = since_off_q + 1'b1;
        e.level = lvl[LW-1:0];
        return e;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task automatic check_result(input logic [23:0] word);
        envelope_t want;
        if (expected_env.size() == 0)
        begin
            report_mismatch($sformatf("result %06h with no tick pending", word));
            return;
        end
        want = expected_env.pop_front();
        if (word[LW-1:0] !== want.level)
            report_mismatch($sformatf("level %0d, expected %0d",
                                      word[LW-1:0], want.level));
        if (word[LW +: adsr_pkg::PH_W] !== want.phase)
            report_mismatch($sformatf("phase %0d, expected %0d",
                                      word[LW +: adsr_pkg::PH_W], want.phase));
        results_seen++;
    endtask

    // output side: checks each transfer; when stalls are on, stalls in runs of random length
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_result(m_tdata);
        if (!rx_stalls)
            m_tready <= 1'b1;
        else
        begin
            if (rx_run == 0)
            begin
                rx_open = !rx_open;
                if (rx_open)
                    rx_run = $urandom_range(1, 12);
                else if ($urandom_range(0, 7) == 0)
                    rx_run = $urandom_range(20, 60);
                else
                    rx_run = $urandom_range(1, 6);
            end
            else
                rx_run--;
            m_tready <= rx_open;
        end
    end

    task automatic send_tick(input bit on, input bit off);
        int unsigned gap;
        if (tx_burst_left == 0)
        begin
            if (tx_gapless)
                gap = 0;
            else if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(20, 60);
            else
                gap = $urandom_range(0, 12);
            if (gap != 0 && tx_raised)
            begin
                s_tvalid <= 1'b0;
                tx_raised = 1'b0;
            end
            repeat (gap) @(posedge clk);
            tx_burst_left = $urandom_range(1, 16);
        end
        if (!tx_raised)
        begin
            s_tvalid <= 1'b1;
            tx_raised = 1'b1;
        end
        s_tdata <= {6'b0, off, on};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        tx_burst_left--;
        expected_env.push_back(advance_envelope(on, off));
        ticks_sent++;
    endtask

    task automatic wait_drained;
        if (tx_raised)
        begin
            s_tvalid <= 1'b0;
            tx_raised = 1'b0;
        end
        while (expected_env.size() != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IW-1:0] idx, input logic [TW-1:0] value,
                             input bit close);
        if (!cfg_raised)
        begin
            cfg_valid <= 1'b1;
            cfg_raised = 1'b1;
        end
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            adsr_pkg::REG_ATTACK:  attack_q  = value;
            adsr_pkg::REG_DECAY:   decay_q   = value;
            adsr_pkg::REG_RELEASE: release_q = value;
            adsr_pkg::REG_START:   start_q   = value[LW-1:0];
            adsr_pkg::REG_SUSTAIN: sustain_q = value[LW-1:0];
            default: ;
        endcase
        if (close)
        begin
            cfg_valid <= 1'b0;
            cfg_raised = 1'b0;
        end
    endtask

    task automatic apply_config(input logic [TW-1:0] a, input logic [TW-1:0] d,
                                input logic [TW-1:0] r, input logic [TW-1:0] st,
                                input logic [TW-1:0] su);
        wait_drained;
        write_reg(adsr_pkg::REG_ATTACK, a, 1'b0);
        write_reg(adsr_pkg::REG_DECAY, d, 1'b0);
        write_reg(adsr_pkg::REG_RELEASE, r, 1'b0);
        write_reg(adsr_pkg::REG_START, st, 1'b0);
        write_reg(adsr_pkg::REG_SUSTAIN, su, 1'b1);
    endtask

    function automatic logic [TW-1:0] pick_ticks();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return TW'($urandom);
            default: return TW'($urandom_range(1, 24));
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_level();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return TW'(FULL_SCALE);
            2: return TW'($urandom);
            3: return TW'($urandom_range(1, 2 * adsr_pkg::SMALL_LEVEL + 1));
            default: return TW'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    // gate clear out of reset: release ramps down from the sustain level
    task automatic test_after_reset;
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_phase_walk;
        apply_config(2, 2, 3, FULL_SCALE, FULL_SCALE / 2);
        send_tick(1'b1, 1'b0);
        repeat (5) send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        repeat (3) send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
    endtask

    task automatic test_zero_lengths;
        apply_config(0, 0, 0, FULL_SCALE, FULL_SCALE / 2);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        apply_config(0, 1, 5, FULL_SCALE, FULL_SCALE / 2);
        send_tick(1'b1, 1'b0);
    endtask

    task automatic test_level_extremes;
        apply_config('1, '1, '1, '1, '0);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        apply_config(1, '1, 1, '1, FULL_SCALE);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        // levels right at and just above the small-level threshold
        apply_config(0, 0, 8, FULL_SCALE, adsr_pkg::SMALL_LEVEL);
        send_tick(1'b1, 1'b0);
        apply_config(0, 0, 8, FULL_SCALE, adsr_pkg::SMALL_LEVEL + 1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
    endtask

    task automatic test_unused_index;
        wait_drained;
        for (int k = FIRST_UNUSED_IDX; k < (1 << IW); k++)
            write_reg(IW'(k), TW'($urandom), k == (1 << IW) - 1);
        send_tick(1'b1, 1'b0);
    endtask

    task automatic test_random_envelopes;
        int unsigned hold, tail;
        while (ticks_sent < ITEM_GOAL)
        begin
            apply_config(pick_ticks(), pick_ticks(), pick_ticks(), pick_level(), pick_level());
            tx_gapless = ($urandom_range(0, 3) == 0);
            rx_stalls  = ($urandom_range(0, 3) != 0);
            repeat ($urandom_range(2, 4))
            begin
                send_tick(1'b1, $urandom_range(0, 15) == 0);
                hold = $urandom_range(0, 50);
                repeat (hold)
                    send_tick($urandom_range(0, 19) == 0, $urandom_range(0, 29) == 0);
                send_tick($urandom_range(0, 9) == 0, 1'b1);
                tail = $urandom_range(0, 40);
                repeat (tail)
                    send_tick($urandom_range(0, 29) == 0, $urandom_range(0, 19) == 0);
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_after_reset;
        test_phase_walk;
        test_zero_lengths;
        test_level_extremes;
        test_unused_index;
        test_random_envelopes;
        wait_drained;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_env.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results pending", expected_env.size());
        $display("FAIL");
        $finish;
    end

endmodule
